/* src/bsc_pkg.sv */
// constants and types for the bcd stopwatch counter
package bsc_pkg;

  localparam int unsigned KEY_W      = 8;
  localparam int unsigned PRESCALE_W = 8;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [5:0] KEY_TOGGLE = 6'h1A;
  localparam logic [5:0] KEY_CLEAR  = 6'h1B;

  localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd40;

  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_KEY  = 1'b1;

  // hh:mm:ss.hh digits, hundredths at the bottom
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
    logic [3:0] tenths;
    logic [3:0] hundredths;
  } digits_t;

  localparam digits_t DIGITS_ZERO = '0;

endpackage

/* src/bcd_stopwatch_counter_top.sv */
// bcd stopwatch counter: hh:mm:ss.hh with prescaler, run/stop and clear keys
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | slave     | in_tvalid/in_tready  | tdata keycode, tuser action
//  out     | master    | out_tvalid/out_tready| tdata digits and running flag
//  cfg     | slave     | cfg_valid/cfg_ready  | cfg_data prescale
//
// one item per clock while in_tready is high; its result appears in the output register the cycle after transfer
// the state registers and the output register are both loaded in the transfer cycle,
// so a waiting result never stops the next item while out_tready is high
// in_tready drops only while the output register is full and out_tready is low
// reset (synchronous, rst_n low) stops the watch, clears digits and prescaler, prescale = 40
module bcd_stopwatch_counter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bsc_pkg::KEY_W-1:0]            in_tdata,  // [7:0] keycode
  input  logic [0:0]                           in_tuser,  // [0] action
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [3:0] hundredths, [7:4] tenths, [11:8] sec_units, [14:12] sec_tens,
  // [18:15] min_units, [21:19] min_tens, [25:22] hour_units, [27:26] hour_tens,
  // [28] running, [31:29] zero
  output logic [bsc_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bsc_pkg::PRESCALE_W-1:0]       cfg_data
);

  logic [bsc_pkg::PRESCALE_W-1:0] prescale_r;
  logic [bsc_pkg::PRESCALE_W-1:0] tick_r, tick_nxt;
  bsc_pkg::digits_t               digits_r, digits_nxt, digits_adv;
  logic                           run_r, run_nxt;
  logic                           out_valid_r;
  logic [bsc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                           in_xfer;
  logic [5:0]                     key;
  logic [bsc_pkg::PRESCALE_W:0]   tick_inc;
  logic                           c1, c2, c3, c4, c5, c6;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign key       = in_tdata[5:0];
  assign tick_inc  = {1'b0, tick_r} + 9'd1;

  // one hundredth forward, carry rippling through the digits
  always_comb begin
    digits_adv = digits_r;
    c1 = (digits_r.hundredths == 4'd9);
    digits_adv.hundredths = c1 ? 4'd0 : digits_r.hundredths + 4'd1;
    c2 = c1 && (digits_r.tenths == 4'd9);
    if (c1) begin
      digits_adv.tenths = (digits_r.tenths == 4'd9) ? 4'd0 : digits_r.tenths + 4'd1;
    end
    c3 = c2 && (digits_r.sec_units == 4'd9);
    if (c2) begin
      digits_adv.sec_units = (digits_r.sec_units == 4'd9) ? 4'd0 : digits_r.sec_units + 4'd1;
    end
    c4 = c3 && (digits_r.sec_tens == 3'd5);
    if (c3) begin
      digits_adv.sec_tens = (digits_r.sec_tens == 3'd5) ? 3'd0 : digits_r.sec_tens + 3'd1;
    end
    c5 = c4 && (digits_r.min_units == 4'd9);
    if (c4) begin
      digits_adv.min_units = (digits_r.min_units == 4'd9) ? 4'd0 : digits_r.min_units + 4'd1;
    end
    c6 = c5 && (digits_r.min_tens == 3'd5);
    if (c5) begin
      digits_adv.min_tens = (digits_r.min_tens == 3'd5) ? 3'd0 : digits_r.min_tens + 3'd1;
    end
    if (c6) begin
      if (digits_r.hour_units == 4'd9) begin
        digits_adv.hour_units = 4'd0;
        digits_adv.hour_tens  = (digits_r.hour_tens == 2'd2) ? 2'd0 : digits_r.hour_tens + 2'd1;
      end else begin
        digits_adv.hour_units = digits_r.hour_units + 4'd1;
      end
    end
    // wrap at 24 hours
    if (digits_adv.hour_tens == 2'd2 && digits_adv.hour_units == 4'd4) begin
      digits_adv = bsc_pkg::DIGITS_ZERO;
    end
  end

  always_comb begin
    tick_nxt   = tick_r;
    digits_nxt = digits_r;
    run_nxt    = run_r;
    if (in_tuser[0] == bsc_pkg::ACTION_TICK) begin
      if (run_r) begin
        if (tick_inc >= {1'b0, prescale_r}) begin
          tick_nxt   = '0;
          digits_nxt = digits_adv;
        end else begin
          tick_nxt = tick_inc[bsc_pkg::PRESCALE_W-1:0];
        end
      end
    end else if (key == bsc_pkg::KEY_TOGGLE) begin
      run_nxt = !run_r;
    end else if (key == bsc_pkg::KEY_CLEAR) begin
      run_nxt    = 1'b0;
      digits_nxt = bsc_pkg::DIGITS_ZERO;
    end
    out_data_nxt = {3'b000, run_nxt, digits_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r  <= bsc_pkg::PRESCALE_RESET;
      tick_r      <= '0;
      digits_r    <= bsc_pkg::DIGITS_ZERO;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        prescale_r <= cfg_data;
      end
      if (in_xfer) begin
        tick_r      <= tick_nxt;
        digits_r    <= digits_nxt;
        run_r       <= run_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // hundredths, tens and hour digits stay inside their radix and below 24 hours
  assert property (@(posedge clk) disable iff (!rst_n)
    digits_r.sec_tens <= 3'd5 && digits_r.min_tens <= 3'd5 &&
    digits_r.hundredths <= 4'd9 && digits_r.hour_units <= 4'd9 &&
    !(digits_r.hour_tens == 2'd2 && digits_r.hour_units >= 4'd4) &&
    digits_r.hour_tens != 2'd3)
    else $error("digit out of range");

  // clear key stops the watch and zeroes every digit
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser[0] == bsc_pkg::ACTION_KEY && in_tdata[5:0] == bsc_pkg::KEY_CLEAR
    |=> !run_r && digits_r == bsc_pkg::DIGITS_ZERO)
    else $error("clear key did not clear");

  // a tick while stopped leaves the count alone
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser[0] == bsc_pkg::ACTION_TICK && !run_r
    |=> $stable(digits_r) && $stable(tick_r))
    else $error("stopped watch advanced");

  // every transfer in leaves a result in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_tvalid && out_tdata[28] == run_r)
    else $error("result missing after transfer");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the bcd stopwatch counter with its own digit predictor
module testbench;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RADIX_DEC       = 10;
  localparam int RADIX_SIX       = 6;
  localparam int RADIX_HOUR_TENS = 3;
  localparam int WRAP_HOUR_TENS  = 2;
  localparam int WRAP_HOUR_UNITS = 4;
  localparam int SETTLE_CYCLES   = 8;

  typedef struct packed {
    logic                      action;
    logic [bsc_pkg::KEY_W-1:0] keycode;
  } watch_event_t;

  typedef struct packed {
    logic             running;
    bsc_pkg::digits_t digits;
  } reading_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [bsc_pkg::KEY_W-1:0]      in_tdata   = '0;
  logic [0:0]                     in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [bsc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [bsc_pkg::PRESCALE_W-1:0] cfg_data   = '0;

  // predictor state
  logic [bsc_pkg::PRESCALE_W-1:0] ps_limit = bsc_pkg::PRESCALE_RESET;
  logic [7:0]            tick_cnt = '0;
  logic [3:0]            digit_reg [8];
  logic                  run_on   = 1'b0;

  watch_event_t events_waiting [$];
  reading_t     readings_due [$];
  watch_event_t in_flight;
  reading_t     want_rd, seen_rd;

  bit gen_run = 1'b0;
  bit calm    = 1'b0;
  int idle_odds = 6;
  int in_gap  = 0;
  int out_gap = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int readings_checked = 0;
  int advance_count = 0;
  int toggle_count = 0;
  int clear_count = 0;
  int wrap_count = 0;
  int prescale_writes = 0;

  bcd_stopwatch_counter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    for (int i = 0; i < 8; i++) digit_reg[i] = 4'd0;
  end

  function automatic void clear_watch();
    int i;
    for (i = 0; i < 8; i++) digit_reg[i] = 4'd0;
  endfunction

  // next reading after one event, updating the predictor state
  function automatic reading_t apply_event(watch_event_t ev);
    reading_t r;
    logic     carry;
    int       i;
    int       radix;
    if (ev.action == bsc_pkg::ACTION_TICK) begin
      if (run_on) begin
        if (int'(tick_cnt) + 1 >= int'(ps_limit)) begin
          tick_cnt = '0;
          advance_count++;
          carry = 1'b1;
          for (i = 0; i < 8; i++) begin
            radix = (i == 3 || i == 5) ? RADIX_SIX : (i == 7) ? RADIX_HOUR_TENS : RADIX_DEC;
            if (carry) begin
              if (int'(digit_reg[i]) + 1 >= radix) begin
                digit_reg[i] = 4'd0;
              end else begin
                digit_reg[i] = digit_reg[i] + 4'd1;
                carry = 1'b0;
              end
            end
          end
          if (digit_reg[7] == WRAP_HOUR_TENS && digit_reg[6] == WRAP_HOUR_UNITS) begin
            clear_watch();
            wrap_count++;
          end
        end else begin
          tick_cnt = tick_cnt + 8'd1;
        end
      end
    end else if (ev.keycode[5:0] == bsc_pkg::KEY_TOGGLE) begin
      run_on = ~run_on;
      toggle_count++;
    end else if (ev.keycode[5:0] == bsc_pkg::KEY_CLEAR) begin
      run_on = 1'b0;
      clear_watch();
      clear_count++;
    end
    r.running           = run_on;
    r.digits.hundredths = digit_reg[0];
    r.digits.tenths     = digit_reg[1];
    r.digits.sec_units  = digit_reg[2];
    r.digits.sec_tens   = digit_reg[3][2:0];
    r.digits.min_units  = digit_reg[4];
    r.digits.min_tens   = digit_reg[5][2:0];
    r.digits.hour_units = digit_reg[6];
    r.digits.hour_tens  = digit_reg[7][1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int want, int seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endfunction

  function automatic void check_reading(reading_t want, reading_t seen);
    check_field("hundredths", want.digits.hundredths, seen.digits.hundredths);
    check_field("tenths",     want.digits.tenths,     seen.digits.tenths);
    check_field("sec_units",  want.digits.sec_units,  seen.digits.sec_units);
    check_field("sec_tens",   want.digits.sec_tens,   seen.digits.sec_tens);
    check_field("min_units",  want.digits.min_units,  seen.digits.min_units);
    check_field("min_tens",   want.digits.min_tens,   seen.digits.min_tens);
    check_field("hour_units", want.digits.hour_units, seen.digits.hour_units);
    check_field("hour_tens",  want.digits.hour_tens,  seen.digits.hour_tens);
    check_field("running",    want.running,           seen.running);
  endfunction

  // driver: hold each event until its transfer, with random gaps in between
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        readings_due.push_back(apply_event(in_flight));
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, idle_odds) == 0) begin
          in_gap = $urandom_range(0, 18);
          in_tvalid <= 1'b0;
        end else if (events_waiting.size() > 0) begin
          in_flight = events_waiting.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= in_flight.keycode;
          in_tuser  <= in_flight.action;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, every output transfer checked in order
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (readings_due.size() == 0) begin
          $error("unexpected reading 0x%h", out_tdata);
          fail_count++;
        end else begin
          want_rd = readings_due.pop_front();
          seen_rd = out_tdata[28:0];
          check_reading(want_rd, seen_rd);
          readings_checked++;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, idle_odds) == 0) begin
        out_gap = $urandom_range(0, 18);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // run state is decided by keys alone, so it can be tracked while queueing
  task automatic queue_event(input logic action, input logic [bsc_pkg::KEY_W-1:0] code);
    watch_event_t ev;
    ev.action  = action;
    ev.keycode = code;
    events_waiting.push_back(ev);
    if (action == bsc_pkg::ACTION_KEY) begin
      if (code[5:0] == bsc_pkg::KEY_TOGGLE) gen_run = !gen_run;
      else if (code[5:0] == bsc_pkg::KEY_CLEAR) gen_run = 1'b0;
    end
  endtask

  // steady: ticks and ignored keys only, so the watch keeps counting
  task automatic queue_random(input bit steady);
    logic [bsc_pkg::KEY_W-1:0] code;
    logic [1:0]                upper;
    int                        roll;
    code  = 8'($urandom_range(0, 255));
    upper = 2'($urandom_range(0, 3));
    roll  = $urandom_range(0, 99);
    if (roll >= 12) begin
      queue_event(bsc_pkg::ACTION_TICK, code);
    end else if (steady) begin
      if (code[5:0] == bsc_pkg::KEY_TOGGLE || code[5:0] == bsc_pkg::KEY_CLEAR) begin
        code[2] = ~code[2];
      end
      queue_event(bsc_pkg::ACTION_KEY, code);
    end else if (!gen_run && roll < 8) begin
      queue_event(bsc_pkg::ACTION_KEY, {upper, bsc_pkg::KEY_TOGGLE});
    end else if (gen_run && roll < 1) begin
      queue_event(bsc_pkg::ACTION_KEY, {upper, bsc_pkg::KEY_CLEAR});
    end else if (gen_run && roll < 4) begin
      queue_event(bsc_pkg::ACTION_KEY, {upper, bsc_pkg::KEY_TOGGLE});
    end else begin
      queue_event(bsc_pkg::ACTION_KEY, code);
    end
  endtask

  task automatic wait_for_idle();
    do @(negedge clk);
    while (events_waiting.size() != 0 || in_tvalid || readings_due.size() != 0);
  endtask

  task automatic write_prescale(input logic [bsc_pkg::PRESCALE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ps_limit = value;
    prescale_writes++;
  endtask

  task automatic run_phase(input logic [bsc_pkg::PRESCALE_W-1:0] ps, input int count,
                           input bit steady, input int odds);
    int n;
    wait_for_idle();
    write_prescale(ps);
    idle_odds = odds;
    @(negedge clk);
    if (!gen_run) queue_event(bsc_pkg::ACTION_KEY, {2'b00, bsc_pkg::KEY_TOGGLE});
    for (n = 0; n < count; n++) queue_random(steady);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: stopped ticks, ignored codes, upper key bits, clear keeping prescaler
    queue_event(bsc_pkg::ACTION_TICK, 8'h00);
    queue_event(bsc_pkg::ACTION_TICK, 8'hFF);
    queue_event(bsc_pkg::ACTION_KEY,  8'h00);
    queue_event(bsc_pkg::ACTION_KEY,  8'hFF);
    queue_event(bsc_pkg::ACTION_KEY,  {2'b11, bsc_pkg::KEY_TOGGLE});
    queue_event(bsc_pkg::ACTION_TICK, {2'b00, bsc_pkg::KEY_CLEAR});
    queue_event(bsc_pkg::ACTION_TICK, {2'b00, bsc_pkg::KEY_TOGGLE});
    queue_event(bsc_pkg::ACTION_TICK, 8'hFF);
    queue_event(bsc_pkg::ACTION_KEY,  {2'b10, bsc_pkg::KEY_CLEAR});
    queue_event(bsc_pkg::ACTION_TICK, 8'h00);
    queue_event(bsc_pkg::ACTION_KEY,  {2'b01, bsc_pkg::KEY_TOGGLE});
    queue_event(bsc_pkg::ACTION_KEY,  8'h3A);
    queue_event(bsc_pkg::ACTION_KEY,  {2'b00, bsc_pkg::KEY_TOGGLE});
    queue_event(bsc_pkg::ACTION_KEY,  {2'b00, bsc_pkg::KEY_CLEAR});
    queue_event(bsc_pkg::ACTION_KEY,  {2'b10, bsc_pkg::KEY_TOGGLE});

    run_phase(8'd1,   300, 1'b1, 5);
    // a long count at the top prescale, then a much lower one
    run_phase(8'd255, 120, 1'b1, 30);
    run_phase(8'd3,   150, 1'b0, 3);
    run_phase(8'd2,   100, 1'b0, 12);
    run_phase(8'($urandom_range(1, 255)), 100, 1'b0, 8);
    calm = 1'b1;
    run_phase(8'd1,   280, 1'b0, 8);

    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d events and %0d readings over %0d prescale writes",
             items_sent, readings_checked, prescale_writes);
    $display("%0d hundredth advances, %0d run toggles, %0d clears, %0d day wraps",
             advance_count, toggle_count, clear_count, wrap_count);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
